// ===== hdl/sdtq_pkg.sv =====
// Shared constants and types of the sorted deadline timer queue.
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int MASK_W        = 16;
    localparam int SLOT_FIELD_W  = 4;
    localparam int TIMEOUT_W     = 32;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 8;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_ONESHOT = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Operation applied to every cell of one list in a cycle.
    typedef struct packed {
        logic ins;
        logic del;
        logic pop;
    } list_ctrl_t;

endpackage

// ===== hdl/sdtq_cell.sv =====
// One cell of a sorted list: holds one entry and trades it with its neighbours.
`timescale 1ns / 1ps

module sdtq_cell #(
    parameter int SLOT_W    = 4,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdtq_pkg::list_ctrl_t   ctrl,
    input  logic [SLOT_W-1:0]      key_slot,
    input  logic [TIME_BITS-1:0]   key_dl,
    input  logic                   left_valid,
    input  logic [SLOT_W-1:0]      left_slot,
    input  logic [TIME_BITS-1:0]   left_dl,
    input  logic                   left_le,
    input  logic                   left_rm,
    input  logic                   right_valid,
    input  logic [SLOT_W-1:0]      right_slot,
    input  logic [TIME_BITS-1:0]   right_dl,
    output logic                   valid,
    output logic [SLOT_W-1:0]      slot,
    output logic [TIME_BITS-1:0]   dl,
    output logic                   le,
    output logic                   rm
);

    logic                 valid_reg, valid_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [TIME_BITS-1:0] dl_reg, dl_next;

    assign le = valid_reg && (dl_reg <= key_dl);
    assign rm = left_rm || (valid_reg && (slot_reg == key_slot));

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        dl_next    = dl_reg;
        if (ctrl.ins)
        begin
            // Entries later than the new deadline move one place right.
            if (!le)
            begin
                if (left_le)
                begin
                    valid_next = 1'b1;
                    slot_next  = key_slot;
                    dl_next    = key_dl;
                end
                else
                begin
                    valid_next = left_valid;
                    slot_next  = left_slot;
                    dl_next    = left_dl;
                end
            end
        end
        else if (ctrl.del || ctrl.pop)
        begin
            if (ctrl.pop || rm)
            begin
                valid_next = right_valid;
                slot_next  = right_slot;
                dl_next    = right_dl;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        dl_reg   <= dl_next;
    end

    assign valid = valid_reg;
    assign slot  = slot_reg;
    assign dl    = dl_reg;

endmodule

// ===== hdl/sdtq_list.sv =====
// A deadline-sorted list built as a row of cells; cell 0 is the head.
`timescale 1ns / 1ps

module sdtq_list #(
    parameter int NUM_SLOTS = sdtq_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF,
    parameter int SLOT_W    = $clog2(NUM_SLOTS)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sdtq_pkg::list_ctrl_t   ctrl,
    input  logic [SLOT_W-1:0]      key_slot,
    input  logic [TIME_BITS-1:0]   key_dl,
    output logic                   head_valid,
    output logic [SLOT_W-1:0]      head_slot,
    output logic [TIME_BITS-1:0]   head_dl
);

    logic                 c_valid [NUM_SLOTS];
    logic [SLOT_W-1:0]    c_slot  [NUM_SLOTS];
    logic [TIME_BITS-1:0] c_dl    [NUM_SLOTS];
    logic                 c_le    [NUM_SLOTS];
    logic                 c_rm    [NUM_SLOTS];

    genvar i;
    generate
        for (i = 0; i < NUM_SLOTS; i++)
        begin : g_cell
            logic                 lv, lle, lrm, rv;
            logic [SLOT_W-1:0]    ls, rs;
            logic [TIME_BITS-1:0] ld, rd;

            if (i == 0)
            begin : g_first
                assign lv  = 1'b0;
                assign ls  = '0;
                assign ld  = '0;
                assign lle = 1'b1;
                assign lrm = 1'b0;
            end
            else
            begin : g_mid
                assign lv  = c_valid[i-1];
                assign ls  = c_slot[i-1];
                assign ld  = c_dl[i-1];
                assign lle = c_le[i-1];
                assign lrm = c_rm[i-1];
            end

            if (i == NUM_SLOTS - 1)
            begin : g_last
                assign rv = 1'b0;
                assign rs = '0;
                assign rd = '0;
            end
            else
            begin : g_inner
                assign rv = c_valid[i+1];
                assign rs = c_slot[i+1];
                assign rd = c_dl[i+1];
            end

            sdtq_cell #(
                .SLOT_W    (SLOT_W),
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .key_slot    (key_slot),
                .key_dl      (key_dl),
                .left_valid  (lv),
                .left_slot   (ls),
                .left_dl     (ld),
                .left_le     (lle),
                .left_rm     (lrm),
                .right_valid (rv),
                .right_slot  (rs),
                .right_dl    (rd),
                .valid       (c_valid[i]),
                .slot        (c_slot[i]),
                .dl          (c_dl[i]),
                .le          (c_le[i]),
                .rm          (c_rm[i])
            );
        end
    endgenerate

    assign head_valid = c_valid[0];
    assign head_slot  = c_slot[0];
    assign head_dl    = c_dl[0];

endmodule

// ===== hdl/sorted_deadline_timer_queue.sv =====
// Timer engine with two deadline-sorted cell lists and a wrapping tick counter.
// A command is decoded in S_IDLE; S_DEL unlinks a slot, S_INS links it in a list.
// A tick advances time; S_CHECK pops expired heads, through S_INS on a re-arm,
// until none is left; one expiry leaves the current head per cycle when free.
// The command result leaves through an output register in the cycle after the beat.
// Reset is asynchronous: time 0, no timer armed, both lists empty, list A current.
`timescale 1ns / 1ps

module sorted_deadline_timer_queue #(
    parameter int NUM_SLOTS = sdtq_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // opcode [1:0], slot [5:2], timeout [37:6], zero fill [39:38]
    input  logic [sdtq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status [1:0], expired_slot [5:2], zero fill [7:6]
    output logic [sdtq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // kind [0]
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sdtq_pkg::MASK_W-1:0]       cfg_data
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int MEXT_W = (NUM_SLOTS > sdtq_pkg::MASK_W) ? NUM_SLOTS : sdtq_pkg::MASK_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DEL   = 4'b0010,
        S_INS   = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [sdtq_pkg::MASK_W-1:0] mask_reg;
    logic [TIME_BITS-1:0]        now_reg, now_next;
    logic                        a_cur_reg, a_cur_next;
    logic [NUM_SLOTS-1:0]        armed_reg, armed_next;
    logic [TIME_BITS-1:0]        period_reg [NUM_SLOTS];
    logic [SLOT_W-1:0]           work_slot_reg, work_slot_next;
    logic [TIME_BITS-1:0]        work_time_reg, work_time_next;
    logic                        ins_pend_reg, ins_pend_next;
    logic                        tick_reg, tick_next;
    logic                        pend_reg, pend_next;
    logic [SLOT_W-1:0]           pend_slot_reg, pend_slot_next;
    logic [CNT_W-1:0]            n_reg, n_next;

    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_status_reg, out_status_next;
    logic [sdtq_pkg::SLOT_FIELD_W-1:0] out_slot_reg, out_slot_next;
    logic                        out_kind_reg, out_kind_next;
    logic                        out_last_reg, out_last_next;

    sdtq_pkg::list_ctrl_t  ctrl_a, ctrl_b;
    logic [SLOT_W-1:0]     key_slot;
    logic [TIME_BITS-1:0]  key_dl;
    logic                  a_head_valid, b_head_valid;
    logic [SLOT_W-1:0]     a_head_slot, b_head_slot;
    logic [TIME_BITS-1:0]  a_head_dl, b_head_dl;

    logic [1:0]            in_op;
    logic [sdtq_pkg::SLOT_FIELD_W-1:0] in_slot;
    logic [TIME_BITS-1:0]  in_t;
    logic [SLOT_W-1:0]     in_idx;
    logic [MEXT_W-1:0]     mask_ext;
    logic [NUM_SLOTS-1:0]  os_vec;
    logic                  out_free, in_fire;
    logic [TIME_BITS-1:0]  ins_dl;
    logic                  ins_to_a;
    logic                  h_valid, h_exp;
    logic [SLOT_W-1:0]     h_slot;
    logic [TIME_BITS-1:0]  h_dl;

    assign in_op    = s_axis_tdata[1:0];
    assign in_slot  = s_axis_tdata[5:2];
    assign in_t     = TIME_BITS'(s_axis_tdata[37:6]);
    assign in_idx   = SLOT_W'(in_slot);
    assign mask_ext = MEXT_W'(mask_reg);
    assign os_vec   = mask_ext[NUM_SLOTS-1:0];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // New deadline; a sum that wrapped past zero goes to the overflow list.
    assign ins_dl   = now_reg + work_time_reg;
    assign ins_to_a = (ins_dl < now_reg) ? !a_cur_reg : a_cur_reg;
    assign key_slot = work_slot_reg;
    assign key_dl   = ins_dl;

    assign h_valid = a_cur_reg ? a_head_valid : b_head_valid;
    assign h_slot  = a_cur_reg ? a_head_slot  : b_head_slot;
    assign h_dl    = a_cur_reg ? a_head_dl    : b_head_dl;
    assign h_exp   = h_valid && (h_dl <= now_reg) && (n_reg < CNT_W'(NUM_SLOTS));

    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        a_cur_next      = a_cur_reg;
        armed_next      = armed_reg;
        work_slot_next  = work_slot_reg;
        work_time_next  = work_time_reg;
        ins_pend_next   = ins_pend_reg;
        tick_next       = tick_reg;
        pend_next       = pend_reg;
        pend_slot_next  = pend_slot_reg;
        n_next          = n_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        ctrl_a          = '0;
        ctrl_b          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == sdtq_pkg::OP_TICK)
                    begin
                        now_next = now_reg + 1'b1;
                        if (now_next == '0)
                            a_cur_next = !a_cur_reg;
                        n_next     = '0;
                        pend_next  = 1'b0;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = sdtq_pkg::KIND_STATUS;
                        out_slot_next   = in_slot;
                        out_last_next   = 1'b1;
                        out_status_next = sdtq_pkg::ST_OK;
                        work_slot_next  = in_idx;
                        work_time_next  = in_t;
                        tick_next       = 1'b0;
                        ins_pend_next   = 1'b0;
                        if (int'(in_slot) >= NUM_SLOTS)
                            out_status_next = sdtq_pkg::ST_INVALID;
                        else
                        begin
                            case (in_op)
                                sdtq_pkg::OP_START:
                                begin
                                    if (os_vec[in_idx] && (in_t != '0))
                                        out_status_next = sdtq_pkg::ST_INVALID;
                                    else
                                    begin
                                        ins_pend_next = (in_t != '0);
                                        if (armed_reg[in_idx])
                                            state_next = S_DEL;
                                        else if (in_t != '0)
                                            state_next = S_INS;
                                    end
                                end
                                sdtq_pkg::OP_ONESHOT:
                                begin
                                    if (!os_vec[in_idx])
                                        out_status_next = sdtq_pkg::ST_INVALID;
                                    else if (armed_reg[in_idx])
                                        out_status_next = sdtq_pkg::ST_BUSY;
                                    else if (in_t != '0)
                                        state_next = S_INS;
                                end
                                default:
                                begin
                                    if (armed_reg[in_idx])
                                        out_status_next = sdtq_pkg::ST_BUSY;
                                end
                            endcase
                        end
                    end
                end
            end
            S_DEL:
            begin
                ctrl_a.del                = 1'b1;
                ctrl_b.del                = 1'b1;
                armed_next[work_slot_reg] = 1'b0;
                state_next                = ins_pend_reg ? S_INS : S_IDLE;
            end
            S_INS:
            begin
                ctrl_a.ins                = ins_to_a;
                ctrl_b.ins                = !ins_to_a;
                armed_next[work_slot_reg] = 1'b1;
                state_next                = tick_reg ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                if (out_free)
                begin
                    // An expiry goes out once it is known whether another follows.
                    if (pend_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_kind_next   = sdtq_pkg::KIND_EXPIRY;
                        out_status_next = sdtq_pkg::ST_OK;
                        out_slot_next   = sdtq_pkg::SLOT_FIELD_W'(pend_slot_reg);
                        out_last_next   = !h_exp;
                    end
                    if (h_exp)
                    begin
                        ctrl_a.pop         = a_cur_reg;
                        ctrl_b.pop         = !a_cur_reg;
                        armed_next[h_slot] = 1'b0;
                        pend_next          = 1'b1;
                        pend_slot_next     = h_slot;
                        n_next             = n_reg + 1'b1;
                        if (!os_vec[h_slot])
                        begin
                            work_slot_next = h_slot;
                            work_time_next = period_reg[h_slot];
                            tick_next      = 1'b1;
                            state_next     = S_INS;
                        end
                    end
                    else
                    begin
                        pend_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mask_reg      <= '0;
            now_reg       <= '0;
            a_cur_reg     <= 1'b1;
            armed_reg     <= '0;
            ins_pend_reg  <= 1'b0;
            tick_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
                mask_reg  <= cfg_data;
            now_reg       <= now_next;
            a_cur_reg     <= a_cur_next;
            armed_reg     <= armed_next;
            ins_pend_reg  <= ins_pend_next;
            tick_reg      <= tick_next;
            pend_reg      <= pend_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_slot_reg  <= work_slot_next;
        work_time_reg  <= work_time_next;
        pend_slot_reg  <= pend_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_kind_reg   <= out_kind_next;
        out_last_reg   <= out_last_next;
        if ((state_reg == S_INS) && !tick_reg)
            period_reg[work_slot_reg] <= work_time_reg;
    end

    sdtq_list #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS),
        .SLOT_W    (SLOT_W)
    ) u_list_a (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_a),
        .key_slot   (key_slot),
        .key_dl     (key_dl),
        .head_valid (a_head_valid),
        .head_slot  (a_head_slot),
        .head_dl    (a_head_dl)
    );

    sdtq_list #(
        .NUM_SLOTS (NUM_SLOTS),
        .TIME_BITS (TIME_BITS),
        .SLOT_W    (SLOT_W)
    ) u_list_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_b),
        .key_slot   (key_slot),
        .key_dl     (key_dl),
        .head_valid (b_head_valid),
        .head_slot  (b_head_slot),
        .head_dl    (b_head_dl)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_slot_reg, out_status_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
